// ===== hw/rtl/pavg_pkg.sv =====
// Shared types and constants for the per-sensor average accumulator.
// Used by every RTL file of the block; depends on nothing.
package pavg_pkg;

  localparam int ID_W        = 7;
  localparam int TEMP_W      = 16;
  localparam int AVG_W       = 20;
  localparam int SUM_W       = 32;
  localparam int CNT_W       = 16;
  localparam int FRAC_W      = 4;
  localparam int NUM_IDS_DEF = 100;

  // func field codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic                     func;
    logic [ID_W-1:0]          sensor_id;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]         out_id;
    logic signed [AVG_W-1:0] average;
    logic [ID_W-1:0]         distinct_count;
    logic                    last;
    logic                    empty_res;
  } out_item_t;

  // command word passed from the front queue to the back end
  typedef struct packed {
    logic                     func;
    logic [ID_W-1:0]          id;
    logic signed [TEMP_W-1:0] temp;
  } cmd_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [AVG_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/pavg_front.sv =====
// Front end: accepts input words, drops adds for ids out of range and
// queues the rest in a two-entry queue for the back end. Uses pavg_pkg.
module pavg_front #(
  parameter int NUM_IDS = pavg_pkg::NUM_IDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pavg_pkg::in_item_t in_item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output pavg_pkg::cmd_t     cmd
);
  import pavg_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  cmd_t             q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0] occ_r;
  logic             keep, push, pop;

  assign keep = (in_item.func == FUNC_DRAIN) || (in_item.sensor_id < ID_W'(NUM_IDS));
  assign in_ready  = (occ_r != OCC_W'(DEPTH));
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (occ_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      occ_r <= occ_r + 1'b1;
      else if (pop && !push) occ_r <= occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{func: in_item.func, id: in_item.sensor_id,
                         temp: in_item.temperature};
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("queue occupancy above depth");

endmodule

// ===== hw/rtl/pavg_div.sv =====
// Signed average divider: (sum * 16) / count, truncated toward zero,
// one quotient bit per cycle. Uses pavg_pkg.
module pavg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pavg_pkg::div_req_t req,
  output pavg_pkg::div_rsp_t rsp
);
  import pavg_pkg::*;

  localparam int MAG_W  = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(AVG_W + 1);

  logic                    busy_r, done_r, neg_r;
  logic [STEP_W-1:0]       step_r;
  logic [CNT_W-1:0]        rem_r, den_r;
  logic [AVG_W-1:0]        dvd_r, q_r;
  logic signed [AVG_W-1:0] quot_r;

  logic [SUM_W-1:0] abs_sum;
  logic [MAG_W-1:0] mag;
  logic [CNT_W+1:0] diff;
  logic             ge;
  logic [AVG_W-1:0] q_fin;

  assign abs_sum = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
  assign mag     = {abs_sum, FRAC_W'(0)};
  // the remainder stays below the divisor, so the trial value fits
  assign diff    = {1'b0, rem_r, dvd_r[AVG_W-1]} - {2'b00, den_r};
  assign ge      = !diff[CNT_W+1];
  assign q_fin   = {q_r[AVG_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(AVG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.sum[SUM_W-1];
      den_r <= req.cnt;
      rem_r <= mag[MAG_W-1 -: CNT_W];
      dvd_r <= mag[AVG_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : {rem_r[CNT_W-2:0], dvd_r[AVG_W-1]};
      dvd_r <= {dvd_r[AVG_W-2:0], 1'b0};
      q_r   <= q_fin;
      if (step_r == STEP_W'(AVG_W - 1)) begin
        quot_r <= neg_r ? AVG_W'(-q_fin) : q_fin;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== hw/rtl/pavg_back.sv =====
// Back end: per-id sum/count store, add read-modify-write, drain scan,
// output register. Uses pavg_pkg; drives the pavg_div request.
module pavg_back #(
  parameter int NUM_IDS = pavg_pkg::NUM_IDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  pavg_pkg::cmd_t      cmd,
  output pavg_pkg::div_req_t  div_req,
  input  pavg_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output pavg_pkg::out_item_t out_item
);
  import pavg_pkg::*;

  localparam int IDX_W = $clog2(NUM_IDS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD_WR = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRD    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } entry_t;

  entry_t mem [NUM_IDS];
  entry_t rd_data_r, wr_data;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic [2:0]         state_r, state_nxt;
  logic [NUM_IDS-1:0] valid_r, valid_nxt;
  logic [ID_W-1:0]    distinct_r, distinct_nxt;
  logic [ID_W-1:0]    cursor_r, cursor_nxt;
  logic [ID_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic               found_r, found_nxt;
  logic               wrap_r, wrap_nxt;
  logic               last_r, last_nxt;
  logic               empty_r, empty_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    fid_r, fid_nxt;
  logic [ID_W-1:0]    add_id_r, add_id_nxt;
  logic signed [TEMP_W-1:0] add_temp_r, add_temp_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic             scan_end, scan_hit;
  logic [IDX_W-1:0] add_idx;
  logic             add_hit;
  entry_t           cur;

  assign scan_end = (scan_idx_r >= ID_W'(NUM_IDS));
  assign scan_hit = !scan_end && valid_r[scan_idx_r[IDX_W-1:0]];
  assign add_idx  = add_id_r[IDX_W-1:0];
  assign add_hit  = valid_r[add_idx];
  // an entry without its valid bit reads as zero
  assign cur      = add_hit ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    distinct_nxt  = distinct_r;
    cursor_nxt    = cursor_r;
    scan_idx_nxt  = scan_idx_r;
    found_nxt     = found_r;
    wrap_nxt      = wrap_r;
    last_nxt      = last_r;
    empty_nxt     = empty_r;
    fid_nxt       = fid_r;
    add_id_nxt    = add_id_r;
    add_temp_nxt  = add_temp_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_ready     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = add_idx;
    wr_en         = 1'b0;
    wr_addr       = add_idx;
    wr_data.sum   = cur.sum + SUM_W'(add_temp_r);
    wr_data.cnt   = cur.cnt + 1'b1;
    div_req.start = 1'b0;
    div_req.sum   = rd_data_r.sum;
    div_req.cnt   = rd_data_r.cnt;

    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.func == FUNC_ADD) begin
            rd_en        = 1'b1;
            rd_addr      = cmd.id[IDX_W-1:0];
            add_id_nxt   = cmd.id;
            add_temp_nxt = cmd.temp;
            state_nxt    = ST_ADD_WR;
          end else begin
            scan_idx_nxt = cursor_r;
            found_nxt    = 1'b0;
            wrap_nxt     = 1'b0;
            empty_nxt    = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_ADD_WR: begin
        // drop readings once the count is saturated
        if (cur.cnt != CNT_MAX) begin
          wr_en = 1'b1;
          if (!add_hit) begin
            valid_nxt[add_idx] = 1'b1;
            distinct_nxt       = distinct_r + 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (!found_r) begin
          if (scan_end) begin
            if (!wrap_r) begin
              wrap_nxt     = 1'b1;
              scan_idx_nxt = '0;
            end else begin
              empty_nxt = 1'b1;
              state_nxt = ST_EMIT;
            end
          end else if (scan_hit) begin
            fid_nxt      = scan_idx_r;
            found_nxt    = 1'b1;
            scan_idx_nxt = scan_idx_r + 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end else begin
          // after a hit: look for any present id above the one found
          if (scan_end || scan_hit) begin
            last_nxt  = scan_end;
            rd_en     = 1'b1;
            rd_addr   = fid_r[IDX_W-1:0];
            state_nxt = ST_DRD;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
      end
      ST_DRD: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (empty_r) begin
            out_item_nxt           = '0;
            out_item_nxt.empty_res = 1'b1;
          end else begin
            out_item_nxt.out_id         = fid_r;
            out_item_nxt.average        = div_rsp.quot;
            out_item_nxt.distinct_count = distinct_r;
            out_item_nxt.last           = last_r;
            out_item_nxt.empty_res      = 1'b0;
          end
          if (empty_r || last_r) begin
            valid_nxt    = '0;
            distinct_nxt = '0;
            cursor_nxt   = '0;
          end else begin
            cursor_nxt = fid_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      distinct_r  <= '0;
      cursor_r    <= '0;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      wrap_r      <= 1'b0;
      last_r      <= 1'b0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      distinct_r  <= distinct_nxt;
      cursor_r    <= cursor_nxt;
      scan_idx_r  <= scan_idx_nxt;
      found_r     <= found_nxt;
      wrap_r      <= wrap_nxt;
      last_r      <= last_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fid_r      <= fid_nxt;
    add_id_r   <= add_id_nxt;
    add_temp_r <= add_temp_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r == ID_W'($countones(valid_r)))
    else $error("distinct count out of step with present ids");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.empty_res |->
      out_item_r.out_id == '0 && out_item_r.average == '0 &&
      out_item_r.distinct_count == '0 && !out_item_r.last)
    else $error("empty result carries nonzero fields");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < ID_W'(NUM_IDS))
    else $error("drain cursor beyond id range");

endmodule

// ===== hw/rtl/per_sensor_average_accumulator.sv =====
// Top level of the per-sensor average accumulator: front queue, back end
// with the sum/count store, and the average divider. Uses pavg_pkg.
//
//   port group  dir  handshake            word
//   in_         in   in_valid/in_ready    in_item  (func, sensor_id, temperature)
//   out_        out  out_valid/out_ready  out_item (out_id, average, distinct_count,
//                                                   last, empty_res)
//
// An add passes through the queue, then reads the store entry and writes it back.
// A drain scans the present bits, one id per cycle, then reads the store entry and
// runs the divider, one quotient bit per cycle, before the result is emitted.
// Reset (rst_n low, synchronous) clears the present bits at once; no clearing pass.
// The two-entry queue keeps taking words until it is full, while the back end works or a result waits.
module per_sensor_average_accumulator #(
  parameter int NUM_IDS = pavg_pkg::NUM_IDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pavg_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pavg_pkg::out_item_t out_item
);
  import pavg_pkg::*;

  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pavg_front #(.NUM_IDS(NUM_IDS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pavg_back #(.NUM_IDS(NUM_IDS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  pavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
